[hw/rtl/tqle_pkg.sv]
package tqle_pkg;

   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   localparam logic [2:0] CSR_LEARN_RATE  = 3'd0;
   localparam logic [2:0] CSR_DISCOUNT    = 3'd1;
   localparam logic [2:0] CSR_EXPLORE     = 3'd2;
   localparam logic [2:0] CSR_AVERAGE     = 3'd3;
   localparam logic [2:0] CSR_STATES      = 3'd4;
   localparam logic [2:0] CSR_ACTIONS     = 3'd5;

   localparam logic [15:0] LEARN_RATE_RST = 16'd32768;
   localparam logic [15:0] DISCOUNT_RST   = 16'd52429;
   localparam logic [16:0] EXPLORE_RST    = 17'd0;
   localparam logic [8:0]  STATES_RST     = 9'd256;
   localparam logic [3:0]  ACTIONS_RST    = 4'd8;

   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   localparam logic [6:0] DIV_LAST_AVG = 7'd65;
   localparam logic [6:0] DIV_LAST_MOD = 7'd15;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPD_RD,
      ST_UPD_MUL,
      ST_UPD_STEP,
      ST_UPD_RND,
      ST_AVG_PREP,
      ST_DIV,
      ST_AVG_FIN,
      ST_WRITE,
      ST_DIRTY,
      ST_GREEDY,
      ST_RESP
   } state_type;

endpackage

[hw/rtl/tqle_ifs.sv]
interface tqle_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [7:0]         state_index;
   logic signed [31:0] reward;
   logic signed [31:0] terminal_value;
   logic [15:0]        explore_draw;
   logic [15:0]        random_pick;
   modport source (output valid, operation, state_index, reward, terminal_value,
                   explore_draw, random_pick, input ready);
   modport sink (input valid, operation, state_index, reward, terminal_value,
                 explore_draw, random_pick, output ready);
endinterface

interface tqle_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         chosen_action;
   logic               state_invalid;
   logic [31:0]        policy_changes_all;
   logic [31:0]        policy_changes_low;
   logic [31:0]        query_total;
   logic signed [47:0] reward_sum;
   modport source (output valid, chosen_action, state_invalid, policy_changes_all,
                   policy_changes_low, query_total, reward_sum, input ready);
   modport sink (input valid, chosen_action, state_invalid, policy_changes_all,
                 policy_changes_low, query_total, reward_sum, output ready);
endinterface

interface tqle_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [16:0] write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface

[hw/rtl/tqle_ram.sv]
module tqle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tabular_q_learning_engine_unit.sv]
// query: scans the current row of n actions in use, updates the previous pair unless at
// trial start, rescans d dirty rows (0 to 2), and runs the divider when exploring
// end trial: discounted update, or in average mode through a radix-2 divider
// one word in flight at a time, set by the shared row scan over the single value port
// after reset a clearing pass fills the tables, the request side stays not ready until
// it is done; register writes are taken always
module tabular_q_learning_engine_unit #(
   parameter int NUM_STATES  = 256,
   parameter int NUM_ACTIONS = 8
) (
   input  logic      clock,
   input  logic      reset,
   tqle_req_if.sink   req_bus,
   tqle_rsp_if.source rsp_bus,
   tqle_csr_if.sink   csr_bus
);

   localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
   localparam int DW    = $clog2(DEPTH);
   localparam int SW    = $clog2(NUM_STATES);
   localparam int AW    = $clog2(NUM_ACTIONS);
   localparam int AW1   = $clog2(NUM_ACTIONS + 1);
   localparam int SW1   = $clog2(NUM_STATES + 1);
   localparam int MW    = (SW1 > 9) ? SW1 : 9;
   localparam int NW    = (AW1 > 4) ? AW1 : 4;

   tqle_pkg::state_type state_ff, state_in;

   logic [15:0] lr_ff, disc_ff;
   logic [16:0] eps_ff;
   logic        avg_ff;
   logic [8:0]  nst_ff;
   logic [3:0]  nact_ff;

   logic [1:0]         op_ff, op_in;
   logic [SW-1:0]      row_ff, row_in;
   logic signed [31:0] r_ff, r_in;
   logic [15:0]        draw_ff, draw_in, pick_ff, pick_in;
   logic               invalid_ff, invalid_in;

   logic [SW-1:0] prev_state_ff, prev_state_in;
   logic [AW-1:0] prev_act_ff, prev_act_in;
   logic          start_ff, start_in;
   logic [31:0]   cnt_all_ff, cnt_all_in, cnt_low_ff, cnt_low_in, qcnt_ff, qcnt_in;
   logic signed [47:0] rsum_ff, rsum_in;

   logic [1:0]    dv_ff, dv_in;
   logic [SW-1:0] dr0_ff, dr0_in, dr1_ff, dr1_in;
   logic [1:0]    slot_ff, slot_in;

   logic [SW-1:0]      sc_row_ff, sc_row_in;
   logic               sc_cur_ff, sc_cur_in;
   logic [AW1-1:0]     sc_cnt_ff, sc_cnt_in;
   logic               sc_pend_ff, sc_pend_in;
   logic [AW-1:0]      sc_pidx_ff, sc_pidx_in;
   logic signed [31:0] best_val_ff, best_val_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [AW-1:0]      act_ff, act_in;

   logic signed [31:0] v_ff, v_in, q_ff, q_in, newq_ff, newq_in;
   logic [31:0]        vis_ff, vis_in;
   logic signed [48:0] prod1_ff, prod1_in;
   logic signed [51:0] prod2_ff, prod2_in;
   logic signed [64:0] pavg_ff, pavg_in;

   logic [32:0] rem_ff, rem_in, den_ff, den_in;
   logic [65:0] quo_ff, quo_in;
   logic [6:0]  dcnt_ff, dcnt_in, dlast_ff, dlast_in;
   logic        dmod_ff, dmod_in, dneg_ff, dneg_in;

   logic [DW-1:0] clr_cnt_ff, clr_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         o_act_ff, o_act_in;
   logic               o_inv_ff, o_inv_in;
   logic [31:0]        o_all_ff, o_all_in, o_low_ff, o_low_in, o_q_ff, o_q_in;
   logic signed [47:0] o_sum_ff, o_sum_in;

   logic          val_we, vis_we, gr_we;
   logic [DW-1:0] val_waddr, val_raddr, vis_waddr, prev_idx, sc_addr;
   logic [31:0]   val_wdata, vis_wdata, val_rdata, vis_rdata;
   logic [SW-1:0] gr_waddr;
   logic [AW-1:0] gr_wdata, gr_rdata;

   logic [MW-1:0] eff_s;
   logic [NW-1:0] eff_n;
   logic          req_fire, rsp_free, req_valid_state, sc_issue, sc_done, sc_take;
   logic          div_ge, div_last, explore, slot_live, dirty_hit;
   logic [33:0]   div_sh;
   logic [32:0]   div_rem;
   logic [SW-1:0] slot_row;
   logic signed [31:0] req_r;
   logic signed [48:0] rsum_add;

   logic signed [48:0] rnd1_t;
   logic signed [33:0] target;
   logic signed [34:0] diff;
   logic signed [51:0] rnd2_t;
   logic signed [36:0] qsum;
   logic signed [65:0] num;
   logic [65:0]        num_mag;

   tqle_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(val_raddr), .rd_data(val_rdata)
   );

   tqle_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_visit_ram (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_addr(prev_idx), .rd_data(vis_rdata)
   );

   tqle_ram #(.WIDTH(AW), .DEPTH(NUM_STATES)) u_policy_ram (
      .clock(clock), .wr_en(gr_we), .wr_addr(gr_waddr), .wr_data(gr_wdata),
      .rd_addr(sc_row_ff), .rd_data(gr_rdata)
   );

   assign eff_s = (MW'(nst_ff) > MW'(NUM_STATES)) ? MW'(NUM_STATES) : MW'(nst_ff);
   assign eff_n = (nact_ff == 4'd0) ? NW'(1) :
                  (NW'(nact_ff) > NW'(NUM_ACTIONS)) ? NW'(NUM_ACTIONS) : NW'(nact_ff);

   assign req_bus.ready   = (state_ff == tqle_pkg::ST_IDLE);
   assign csr_bus.ready   = 1'b1;
   assign req_fire        = req_bus.valid && req_bus.ready;
   assign rsp_free        = !rsp_valid_ff || rsp_bus.ready;
   assign req_valid_state = MW'(req_bus.state_index) < eff_s;
   assign req_r           = (req_bus.operation == tqle_pkg::OP_INIT) ? 32'sd0 : req_bus.reward;
   assign rsum_add        = {rsum_ff[47], rsum_ff} + 49'(req_r);

   assign prev_idx = DW'(prev_state_ff) * DW'(NUM_ACTIONS) + DW'(prev_act_ff);
   assign sc_addr  = DW'(sc_row_ff) * DW'(NUM_ACTIONS) + DW'(sc_cnt_ff[AW-1:0]);
   assign sc_issue = NW'(sc_cnt_ff) < eff_n;
   assign sc_done  = !sc_issue && !sc_pend_ff;
   assign sc_take  = sc_pend_ff && ((sc_pidx_ff == '0) || ($signed(val_rdata) > best_val_ff));

   assign div_sh   = {rem_ff, quo_ff[65]};
   assign div_ge   = div_sh >= {1'b0, den_ff};
   assign div_rem  = div_ge ? 33'(div_sh - {1'b0, den_ff}) : div_sh[32:0];
   assign div_last = (dcnt_ff == dlast_ff);

   assign explore   = {1'b0, draw_ff} < eps_ff;
   assign slot_row  = slot_ff[0] ? dr1_ff : dr0_ff;
   assign slot_live = dv_ff[slot_ff[0]] && (MW'(slot_row) < eff_s);
   assign dirty_hit = (dv_ff[0] && (dr0_ff == prev_state_ff)) ||
                      (dv_ff[1] && (dr1_ff == prev_state_ff));

   // watkins and average arithmetic
   assign rnd1_t  = prod1_ff + 49'sd32768;
   assign target  = 34'(r_ff) + 34'($signed(rnd1_t[48:16]));
   assign diff    = 35'(target) - 35'(q_ff);
   assign rnd2_t  = prod2_ff + 52'sd32768;
   assign qsum    = 37'(q_ff) + 37'($signed(rnd2_t[51:16]));
   assign num     = 66'(pavg_ff) + 66'(r_ff);
   assign num_mag = num[65] ? 66'(-num) : 66'(num);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tqle_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == DW'(DEPTH - 1)) state_in = tqle_pkg::ST_IDLE;
         end
         tqle_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.operation)
                  tqle_pkg::OP_QUERY, tqle_pkg::OP_INIT: begin
                     state_in = req_valid_state ? tqle_pkg::ST_SCAN : tqle_pkg::ST_RESP;
                  end
                  tqle_pkg::OP_END: state_in = tqle_pkg::ST_UPD_RD;
                  default: state_in = tqle_pkg::ST_IDLE;
               endcase
            end
         end
         tqle_pkg::ST_SCAN: begin
            if (sc_done) begin
               if (!sc_cur_ff) state_in = tqle_pkg::ST_GREEDY;
               else if (start_ff) state_in = tqle_pkg::ST_DIRTY;
               else state_in = tqle_pkg::ST_UPD_RD;
            end
         end
         tqle_pkg::ST_UPD_RD: state_in = tqle_pkg::ST_UPD_MUL;
         tqle_pkg::ST_UPD_MUL: begin
            state_in = (op_ff == tqle_pkg::OP_END && avg_ff) ? tqle_pkg::ST_AVG_PREP
                                                              : tqle_pkg::ST_UPD_STEP;
         end
         tqle_pkg::ST_UPD_STEP: state_in = tqle_pkg::ST_UPD_RND;
         tqle_pkg::ST_UPD_RND:  state_in = tqle_pkg::ST_WRITE;
         tqle_pkg::ST_AVG_PREP: state_in = tqle_pkg::ST_DIV;
         tqle_pkg::ST_DIV: begin
            if (div_last) state_in = dmod_ff ? tqle_pkg::ST_RESP : tqle_pkg::ST_AVG_FIN;
         end
         tqle_pkg::ST_AVG_FIN: state_in = tqle_pkg::ST_WRITE;
         tqle_pkg::ST_WRITE: begin
            state_in = (op_ff == tqle_pkg::OP_END) ? tqle_pkg::ST_IDLE : tqle_pkg::ST_DIRTY;
         end
         tqle_pkg::ST_DIRTY: begin
            if (slot_ff == 2'd2) state_in = explore ? tqle_pkg::ST_DIV : tqle_pkg::ST_RESP;
            else if (slot_live) state_in = tqle_pkg::ST_SCAN;
         end
         tqle_pkg::ST_GREEDY: state_in = tqle_pkg::ST_DIRTY;
         tqle_pkg::ST_RESP: begin
            if (rsp_free) state_in = tqle_pkg::ST_IDLE;
         end
         default: state_in = tqle_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in = op_ff; row_in = row_ff; r_in = r_ff; draw_in = draw_ff; pick_in = pick_ff;
      invalid_in = invalid_ff;
      prev_state_in = prev_state_ff; prev_act_in = prev_act_ff; start_in = start_ff;
      cnt_all_in = cnt_all_ff; cnt_low_in = cnt_low_ff; qcnt_in = qcnt_ff; rsum_in = rsum_ff;
      dv_in = dv_ff; dr0_in = dr0_ff; dr1_in = dr1_ff; slot_in = slot_ff;
      sc_row_in = sc_row_ff; sc_cur_in = sc_cur_ff; sc_cnt_in = sc_cnt_ff;
      sc_pend_in = 1'b0; sc_pidx_in = sc_pidx_ff;
      best_val_in = best_val_ff; best_idx_in = best_idx_ff; act_in = act_ff;
      v_in = v_ff; q_in = q_ff; vis_in = vis_ff; newq_in = newq_ff;
      prod1_in = prod1_ff; prod2_in = prod2_ff; pavg_in = pavg_ff;
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; dcnt_in = dcnt_ff;
      dlast_in = dlast_ff; dmod_in = dmod_ff; dneg_in = dneg_ff;
      clr_cnt_in = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      o_act_in = o_act_ff; o_inv_in = o_inv_ff; o_all_in = o_all_ff; o_low_in = o_low_ff;
      o_q_in = o_q_ff; o_sum_in = o_sum_ff;
      val_we = 1'b0; val_waddr = prev_idx; val_wdata = newq_ff;
      vis_we = 1'b0; vis_waddr = prev_idx;
      vis_wdata = (vis_ff == tqle_pkg::CNT_MAX) ? vis_ff : vis_ff + 32'd1;
      gr_we = 1'b0; gr_waddr = sc_row_ff; gr_wdata = best_idx_ff;
      val_raddr = (state_ff == tqle_pkg::ST_SCAN) ? sc_addr : prev_idx;

      unique case (state_ff)
         tqle_pkg::ST_CLEAR: begin
            val_we = 1'b1; val_waddr = clr_cnt_ff; val_wdata = tqle_pkg::Q_ONE;
            vis_we = 1'b1; vis_waddr = clr_cnt_ff; vis_wdata = '0;
            gr_we = 1'b1; gr_waddr = clr_cnt_ff[SW-1:0]; gr_wdata = '0;
            clr_cnt_in = clr_cnt_ff + DW'(1);
         end
         tqle_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in = req_bus.operation;
               row_in = SW'(req_bus.state_index);
               r_in = req_r;
               v_in = req_bus.terminal_value;
               draw_in = req_bus.explore_draw;
               pick_in = req_bus.random_pick;
               invalid_in = !req_valid_state;
               act_in = '0;
               slot_in = 2'd0;
               sc_row_in = SW'(req_bus.state_index);
               sc_cur_in = 1'b1;
               sc_cnt_in = '0;
               if (rsum_add[48:47] == 2'b01) rsum_in = 48'sh7FFF_FFFF_FFFF;
               else if (rsum_add[48:47] == 2'b10) rsum_in = 48'sh8000_0000_0000;
               else rsum_in = rsum_add[47:0];
               case (req_bus.operation)
                  tqle_pkg::OP_QUERY: begin
                     if (qcnt_ff != tqle_pkg::CNT_MAX) qcnt_in = qcnt_ff + 32'd1;
                  end
                  tqle_pkg::OP_INIT: begin
                     start_in = 1'b1; cnt_low_in = '0; qcnt_in = 32'd1; rsum_in = '0;
                  end
                  tqle_pkg::OP_END: ;
                  default: rsum_in = rsum_ff;
               endcase
            end
         end
         tqle_pkg::ST_SCAN: begin
            if (sc_issue) begin
               sc_pend_in = 1'b1;
               sc_pidx_in = sc_cnt_ff[AW-1:0];
               sc_cnt_in = sc_cnt_ff + AW1'(1);
            end
            if (sc_take) begin
               best_val_in = $signed(val_rdata);
               best_idx_in = sc_pidx_ff;
            end
            if (sc_done && sc_cur_ff) begin
               act_in = best_idx_ff;
               v_in = best_val_ff;
               start_in = 1'b0;
            end
         end
         tqle_pkg::ST_UPD_MUL: begin
            q_in = $signed(val_rdata);
            vis_in = vis_rdata;
            prod1_in = $signed({1'b0, disc_ff}) * v_ff;
            pavg_in = $signed({1'b0, vis_rdata}) * $signed(val_rdata);
         end
         tqle_pkg::ST_UPD_STEP: prod2_in = $signed({1'b0, lr_ff}) * diff;
         tqle_pkg::ST_UPD_RND: begin
            if (qsum[36:31] == 6'b000000 || qsum[36:31] == 6'b111111) newq_in = qsum[31:0];
            else newq_in = qsum[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end
         tqle_pkg::ST_AVG_PREP: begin
            dneg_in = num[65];
            quo_in = num_mag;
            rem_in = '0;
            den_in = {1'b0, vis_ff} + 33'd2;
            dcnt_in = '0;
            dlast_in = tqle_pkg::DIV_LAST_AVG;
            dmod_in = 1'b0;
         end
         tqle_pkg::ST_DIV: begin
            rem_in = div_rem;
            quo_in = {quo_ff[64:0], div_ge};
            dcnt_in = dcnt_ff + 7'd1;
            if (div_last && dmod_ff) act_in = div_rem[AW-1:0];
         end
         tqle_pkg::ST_AVG_FIN: begin
            if (!dneg_ff) begin
               newq_in = (|quo_ff[65:31]) ? 32'sh7FFF_FFFF : $signed(quo_ff[31:0]);
            end else if ((|quo_ff[65:32]) || (quo_ff[31] && (|quo_ff[30:0]))) begin
               newq_in = 32'sh8000_0000;
            end else begin
               newq_in = $signed(-quo_ff[31:0]);
            end
         end
         tqle_pkg::ST_WRITE: begin
            val_we = 1'b1;
            vis_we = 1'b1;
            if (!dirty_hit) begin
               if (!dv_ff[0]) begin
                  dv_in[0] = 1'b1; dr0_in = prev_state_ff;
               end else begin
                  dv_in[1] = 1'b1; dr1_in = prev_state_ff;
               end
            end
         end
         tqle_pkg::ST_DIRTY: begin
            if (slot_ff == 2'd2) begin
               quo_in = {pick_ff, 50'd0};
               rem_in = '0;
               den_in = 33'(eff_n);
               dcnt_in = '0;
               dlast_in = tqle_pkg::DIV_LAST_MOD;
               dmod_in = 1'b1;
            end else if (slot_live) begin
               sc_row_in = slot_row;
               sc_cur_in = 1'b0;
               sc_cnt_in = '0;
            end else begin
               dv_in[slot_ff[0]] = 1'b0;
               slot_in = slot_ff + 2'd1;
            end
         end
         tqle_pkg::ST_GREEDY: begin
            if (gr_rdata != best_idx_ff) begin
               gr_we = 1'b1;
               if (cnt_all_ff != tqle_pkg::CNT_MAX) cnt_all_in = cnt_all_ff + 32'd1;
               if (MW'(sc_row_ff) < (eff_s >> 1) && cnt_low_ff != tqle_pkg::CNT_MAX) begin
                  cnt_low_in = cnt_low_ff + 32'd1;
               end
            end
            dv_in[slot_ff[0]] = 1'b0;
            slot_in = slot_ff + 2'd1;
         end
         tqle_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               o_act_in = 3'(act_ff);
               o_inv_in = invalid_ff;
               o_all_in = cnt_all_ff;
               o_low_in = cnt_low_ff;
               o_q_in = qcnt_ff;
               o_sum_in = rsum_ff;
               if (!invalid_ff) begin
                  prev_state_in = row_ff;
                  prev_act_in = act_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tqle_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
         lr_ff <= tqle_pkg::LEARN_RATE_RST;
         disc_ff <= tqle_pkg::DISCOUNT_RST;
         eps_ff <= tqle_pkg::EXPLORE_RST;
         avg_ff <= 1'b0;
         nst_ff <= tqle_pkg::STATES_RST;
         nact_ff <= tqle_pkg::ACTIONS_RST;
         prev_state_ff <= '0;
         prev_act_ff <= '0;
         start_ff <= 1'b1;
         cnt_all_ff <= '0;
         cnt_low_ff <= '0;
         qcnt_ff <= '0;
         rsum_ff <= '0;
         dv_ff <= '0;
         sc_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         prev_state_ff <= prev_state_in;
         prev_act_ff <= prev_act_in;
         start_ff <= start_in;
         cnt_all_ff <= cnt_all_in;
         cnt_low_ff <= cnt_low_in;
         qcnt_ff <= qcnt_in;
         rsum_ff <= rsum_in;
         dv_ff <= dv_in;
         sc_pend_ff <= sc_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.reg_index)
               tqle_pkg::CSR_LEARN_RATE: lr_ff <= csr_bus.write_data[15:0];
               tqle_pkg::CSR_DISCOUNT:   disc_ff <= csr_bus.write_data[15:0];
               tqle_pkg::CSR_EXPLORE:    eps_ff <= csr_bus.write_data;
               tqle_pkg::CSR_AVERAGE:    avg_ff <= csr_bus.write_data[0];
               tqle_pkg::CSR_STATES:     nst_ff <= csr_bus.write_data[8:0];
               tqle_pkg::CSR_ACTIONS:    nact_ff <= csr_bus.write_data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; row_ff <= row_in; r_ff <= r_in; draw_ff <= draw_in; pick_ff <= pick_in;
      invalid_ff <= invalid_in;
      dr0_ff <= dr0_in; dr1_ff <= dr1_in; slot_ff <= slot_in;
      sc_row_ff <= sc_row_in; sc_cur_ff <= sc_cur_in; sc_cnt_ff <= sc_cnt_in;
      sc_pidx_ff <= sc_pidx_in; best_val_ff <= best_val_in; best_idx_ff <= best_idx_in;
      act_ff <= act_in;
      v_ff <= v_in; q_ff <= q_in; vis_ff <= vis_in; newq_ff <= newq_in;
      prod1_ff <= prod1_in; prod2_ff <= prod2_in; pavg_ff <= pavg_in;
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; dcnt_ff <= dcnt_in;
      dlast_ff <= dlast_in; dmod_ff <= dmod_in; dneg_ff <= dneg_in;
      o_act_ff <= o_act_in; o_inv_ff <= o_inv_in; o_all_ff <= o_all_in;
      o_low_ff <= o_low_in; o_q_ff <= o_q_in; o_sum_ff <= o_sum_in;
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.chosen_action      = o_act_ff;
   assign rsp_bus.state_invalid      = o_inv_ff;
   assign rsp_bus.policy_changes_all = o_all_ff;
   assign rsp_bus.policy_changes_low = o_low_ff;
   assign rsp_bus.query_total        = o_q_ff;
   assign rsp_bus.reward_sum         = o_sum_ff;

endmodule
